/* hdl/rwol_pkg.sv */
// ----------------------------------------------------------------------------
// rwol_pkg
// Shared widths, command codes and control types for the record ring with
// byte-offset lookup.
// ----------------------------------------------------------------------------
package rwol_pkg;

    localparam int HANDLE_W   = 32;
    localparam int LENGTH_W   = 16;
    localparam int POS_W      = 20;
    localparam int SLOT_OUT_W = 4;

    localparam logic CMD_ADD  = 1'b0;
    localparam logic CMD_FIND = 1'b1;

    // control broadcast from the sequencer to every cell
    typedef struct packed {
        logic wr_en;
        logic start;
        logic flush;
    } cell_ctl_t;

    // data of the cell that holds the token
    typedef struct packed {
        logic [HANDLE_W-1:0] handle;
        logic [LENGTH_W-1:0] length;
    } sel_t;

endpackage

/* hdl/rwol_cell.sv */
// ----------------------------------------------------------------------------
// rwol_cell
// One ring slot: holds a record and a token bit that moves to the next cell
// every cycle. Drives its record onto the select bus only while it has the
// token.
// ----------------------------------------------------------------------------
module rwol_cell import rwol_pkg::*; #(
    parameter int SW  = 4,
    parameter int IDX = 0
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  cell_ctl_t           ctl,
    input  logic [SW-1:0]       slot_sel,
    input  logic [HANDLE_W-1:0] wr_handle,
    input  logic [LENGTH_W-1:0] wr_length,
    input  logic                prev_active,
    output logic                active,
    output logic [HANDLE_W-1:0] rd_handle,
    output logic [LENGTH_W-1:0] rd_length
);

    logic                hit;
    logic                active_reg;
    logic [HANDLE_W-1:0] handle_reg;
    logic [LENGTH_W-1:0] length_reg;

    assign hit = (slot_sel == SW'(IDX));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= 1'b0;
        end else if (ctl.start) begin
            active_reg <= hit;
        end else if (ctl.flush) begin
            active_reg <= 1'b0;
        end else begin
            active_reg <= prev_active;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.wr_en && hit) begin
            handle_reg <= wr_handle;
            length_reg <= wr_length;
        end
    end

    assign active    = active_reg;
    assign rd_handle = active_reg ? handle_reg : '0;
    assign rd_length = active_reg ? length_reg : '0;

endmodule

/* hdl/rwol_ctrl.sv */
// ----------------------------------------------------------------------------
// rwol_ctrl
// Sequencer: ring pointers and full flag, add handling, find walk over the
// token position (select stage, then accumulate and compare), result beat.
// ----------------------------------------------------------------------------
module rwol_ctrl import rwol_pkg::*; #(
    parameter int RING_DEPTH = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  s_command,
    input  logic [POS_W-1:0]      s_byte_position,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic                  m_found,
    output logic [SLOT_OUT_W-1:0] m_slot_index,
    output logic [HANDLE_W-1:0]   m_found_handle,
    output logic [LENGTH_W-1:0]   m_found_length,
    output logic [LENGTH_W-1:0]   m_byte_in_record,
    output logic                  m_ring_full,
    output cell_ctl_t             cell_ctl,
    output logic [$clog2(RING_DEPTH)-1:0] slot_sel,
    input  sel_t                  sel
);

    localparam int SW = $clog2(RING_DEPTH);
    localparam int CW = $clog2(RING_DEPTH + 1);
    localparam int BW = (LENGTH_W + SW > POS_W) ? LENGTH_W + SW + 1 : POS_W + 1;
    localparam logic [SW-1:0] LAST_SLOT = SW'(RING_DEPTH - 1);
    localparam logic [CW-1:0] DEPTH_C   = CW'(RING_DEPTH);

    typedef enum logic [1:0] {ST_IDLE, ST_WALK, ST_DONE} state_t;

    state_t                state_reg;
    logic [SW-1:0]         wr_slot_reg;
    logic [SW-1:0]         rd_slot_reg;
    logic                  full_reg;
    logic [POS_W-1:0]      pos_reg;
    logic [BW-1:0]         base_reg;
    logic [CW-1:0]         count_reg;
    logic [CW-1:0]         iss_reg;
    logic [SW-1:0]         cur_slot_reg;
    logic                  sel_valid_reg;
    logic [SW-1:0]         sel_slot_reg;
    logic [HANDLE_W-1:0]   sel_handle_reg;
    logic [LENGTH_W-1:0]   sel_len_reg;

    logic                  res_found_reg;
    logic [SLOT_OUT_W-1:0] res_slot_reg;
    logic [HANDLE_W-1:0]   res_handle_reg;
    logic [LENGTH_W-1:0]   res_length_reg;
    logic [LENGTH_W-1:0]   res_byte_reg;
    logic                  res_full_reg;

    logic                  m_valid_reg;
    logic                  m_found_reg;
    logic [SLOT_OUT_W-1:0] m_slot_reg;
    logic [HANDLE_W-1:0]   m_handle_reg;
    logic [LENGTH_W-1:0]   m_length_reg;
    logic [LENGTH_W-1:0]   m_byte_reg;
    logic                  m_full_reg;

    logic                  accept;
    logic [SW-1:0]         wr_inc;
    logic [SW-1:0]         rd_inc;
    logic [SW-1:0]         cur_inc;
    logic [SW-1:0]         rd_after_add;
    logic [CW-1:0]         wr_ext;
    logic [CW-1:0]         rd_ext;
    logic [CW-1:0]         count_new;
    logic [BW-1:0]         pos_ext;
    logic [BW-1:0]         sum;
    logic [BW-1:0]         diff;
    logic                  step_hit;
    logic [SW+SLOT_OUT_W-1:0] slot_wide;

    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;

    assign wr_inc  = (wr_slot_reg  == LAST_SLOT) ? '0 : wr_slot_reg  + 1'b1;
    assign rd_inc  = (rd_slot_reg  == LAST_SLOT) ? '0 : rd_slot_reg  + 1'b1;
    assign cur_inc = (cur_slot_reg == LAST_SLOT) ? '0 : cur_slot_reg + 1'b1;
    assign rd_after_add = full_reg ? rd_inc : rd_slot_reg;

    assign wr_ext = CW'(wr_slot_reg);
    assign rd_ext = CW'(rd_slot_reg);

    always_comb begin
        if (full_reg) begin
            count_new = DEPTH_C;
        end else if (wr_ext >= rd_ext) begin
            count_new = wr_ext - rd_ext;
        end else begin
            count_new = wr_ext + DEPTH_C - rd_ext;
        end
    end

    assign pos_ext   = BW'(pos_reg);
    assign sum       = base_reg + BW'(sel_len_reg);
    assign diff      = pos_ext - base_reg;
    assign step_hit  = sel_valid_reg && (pos_ext < sum);
    assign slot_wide = {{SLOT_OUT_W{1'b0}}, sel_slot_reg};

    assign slot_sel = (s_command == CMD_ADD) ? wr_slot_reg : rd_slot_reg;

    always_comb begin
        cell_ctl.wr_en = accept && (s_command == CMD_ADD);
        cell_ctl.start = accept && (s_command == CMD_FIND) && (count_new != '0);
        cell_ctl.flush = (state_reg != ST_WALK);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            wr_slot_reg   <= '0;
            rd_slot_reg   <= '0;
            full_reg      <= 1'b0;
            sel_valid_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            // in ST_DONE the output register is reloaded instead
            if (m_valid_reg && m_ready && (state_reg != ST_DONE)) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    sel_valid_reg <= 1'b0;
                    if (accept) begin
                        res_found_reg  <= 1'b0;
                        res_slot_reg   <= '0;
                        res_handle_reg <= '0;
                        res_length_reg <= '0;
                        res_byte_reg   <= '0;
                        if (s_command == CMD_ADD) begin
                            wr_slot_reg  <= wr_inc;
                            rd_slot_reg  <= rd_after_add;
                            full_reg     <= (wr_inc == rd_after_add);
                            res_full_reg <= (wr_inc == rd_after_add);
                            state_reg    <= ST_DONE;
                        end else begin
                            res_full_reg <= full_reg;
                            pos_reg      <= s_byte_position;
                            base_reg     <= '0;
                            count_reg    <= count_new;
                            iss_reg      <= '0;
                            cur_slot_reg <= rd_slot_reg;
                            state_reg    <= (count_new == '0) ? ST_DONE : ST_WALK;
                        end
                    end
                end
                ST_WALK: begin
                    if ((iss_reg != count_reg) && !step_hit) begin
                        sel_valid_reg  <= 1'b1;
                        sel_slot_reg   <= cur_slot_reg;
                        sel_handle_reg <= sel.handle;
                        sel_len_reg    <= sel.length;
                        cur_slot_reg   <= cur_inc;
                        iss_reg        <= iss_reg + 1'b1;
                    end else begin
                        sel_valid_reg <= 1'b0;
                    end
                    if (step_hit) begin
                        res_found_reg  <= 1'b1;
                        res_slot_reg   <= slot_wide[SLOT_OUT_W-1:0];
                        res_handle_reg <= sel_handle_reg;
                        res_length_reg <= sel_len_reg;
                        res_byte_reg   <= diff[LENGTH_W-1:0];
                        state_reg      <= ST_DONE;
                    end else if (sel_valid_reg) begin
                        base_reg <= sum;
                    end else if (iss_reg == count_reg) begin
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    sel_valid_reg <= 1'b0;
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg  <= 1'b1;
                        m_found_reg  <= res_found_reg;
                        m_slot_reg   <= res_slot_reg;
                        m_handle_reg <= res_handle_reg;
                        m_length_reg <= res_length_reg;
                        m_byte_reg   <= res_byte_reg;
                        m_full_reg   <= res_full_reg;
                        state_reg    <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_found          = m_found_reg;
    assign m_slot_index     = m_slot_reg;
    assign m_found_handle   = m_handle_reg;
    assign m_found_length   = m_length_reg;
    assign m_byte_in_record = m_byte_reg;
    assign m_ring_full      = m_full_reg;

    a_full_ptrs: assert property (@(posedge aclk) disable iff (!aresetn)
        full_reg |-> (wr_slot_reg == rd_slot_reg))
        else $error("full ring with unequal slots");

    a_issue_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_WALK) |-> (iss_reg <= count_reg))
        else $error("walk issued past stored records");

    a_sel_in_walk: assert property (@(posedge aclk) disable iff (!aresetn)
        sel_valid_reg |-> (state_reg == ST_WALK))
        else $error("select stage valid outside walk");

    a_base_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_WALK) |-> (base_reg <= pos_ext))
        else $error("accumulated base passed the offset");

endmodule

/* hdl/ring_of_writes_offset_lookup_core.sv */
// ----------------------------------------------------------------------------
// ring_of_writes_offset_lookup_core
// Ring of write records (handle, byte length) with lookup of a byte offset
// into the stored records, oldest first.
//
//   beat     dir  ports                                          when
//   s_       in   command, entry_handle, entry_length, byte_pos   s_valid & s_ready
//   m_       out  found, slot_index, found_handle, found_length,  m_valid & m_ready
//                 byte_in_record, ring_full
//
// Add: the record is written on the input beat; the result goes via ST_DONE.
// Find: a token moves one cell per cycle around the ring of record cells,
//   one stored record visited per cycle.
// One item at a time: s_ready is high between items; a waiting result does
//   not block the next input beat.
// Reset: synchronous, active low; ring empty.
// ----------------------------------------------------------------------------
module ring_of_writes_offset_lookup_core import rwol_pkg::*; #(
    parameter int RING_DEPTH = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  s_command,
    input  logic [HANDLE_W-1:0]   s_entry_handle,
    input  logic [LENGTH_W-1:0]   s_entry_length,
    input  logic [POS_W-1:0]      s_byte_position,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic                  m_found,
    output logic [SLOT_OUT_W-1:0] m_slot_index,
    output logic [HANDLE_W-1:0]   m_found_handle,
    output logic [LENGTH_W-1:0]   m_found_length,
    output logic [LENGTH_W-1:0]   m_byte_in_record,
    output logic                  m_ring_full
);

    localparam int SW = $clog2(RING_DEPTH);

    cell_ctl_t           cell_ctl;
    logic [SW-1:0]       slot_sel;
    sel_t                sel;
    logic                cell_active [RING_DEPTH];
    logic [HANDLE_W-1:0] cell_handle [RING_DEPTH];
    logic [LENGTH_W-1:0] cell_length [RING_DEPTH];
    logic [RING_DEPTH-1:0] active_vec;

    rwol_ctrl #(
        .RING_DEPTH (RING_DEPTH)
    ) u_ctrl (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_command        (s_command),
        .s_byte_position  (s_byte_position),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_found          (m_found),
        .m_slot_index     (m_slot_index),
        .m_found_handle   (m_found_handle),
        .m_found_length   (m_found_length),
        .m_byte_in_record (m_byte_in_record),
        .m_ring_full      (m_ring_full),
        .cell_ctl         (cell_ctl),
        .slot_sel         (slot_sel),
        .sel              (sel)
    );

    for (genvar i = 0; i < RING_DEPTH; i++) begin : g_cell
        rwol_cell #(
            .SW  (SW),
            .IDX (i)
        ) u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .ctl         (cell_ctl),
            .slot_sel    (slot_sel),
            .wr_handle   (s_entry_handle),
            .wr_length   (s_entry_length),
            .prev_active (cell_active[(i + RING_DEPTH - 1) % RING_DEPTH]),
            .active      (cell_active[i]),
            .rd_handle   (cell_handle[i]),
            .rd_length   (cell_length[i])
        );
        assign active_vec[i] = cell_active[i];
    end

    // token cell drives the bus, all others drive zero
    always_comb begin
        sel = '0;
        for (int i = 0; i < RING_DEPTH; i++) begin
            sel.handle = sel.handle | cell_handle[i];
            sel.length = sel.length | cell_length[i];
        end
    end

    a_one_token: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0(active_vec))
        else $error("more than one token in the cell ring");

endmodule

/* test/ring_of_writes_offset_lookup_core_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ring_of_writes_offset_lookup_core_tb
// Self-checking bench for the record ring with byte-offset lookup. A short
// table of directed beats covers the empty ring, zero-length and maximum
// records, the fill to full and the overwrite of the oldest record. Random
// add/find traffic follows. Result beats are checked field by field against
// the ring model in the bench (typed rows: fixed result), with random idling
// on both channels and one long output stall that backs up the input.
// ----------------------------------------------------------------------------
module ring_of_writes_offset_lookup_core_tb;
    import rwol_pkg::*;

    localparam int RING_DEPTH  = 16;
    localparam int RAND_ITEMS  = 1500;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int DRAIN_WAIT  = RING_DEPTH + 20;

    typedef struct packed {
        logic                  found;
        logic [SLOT_OUT_W-1:0] slot;
        logic [HANDLE_W-1:0]   handle;
        logic [LENGTH_W-1:0]   length;
        logic [LENGTH_W-1:0]   offset;
        logic                  full;
    } lookup_result_t;

    // typed rows expect an empty result with the given full flag
    typedef struct packed {
        logic                cmd;
        logic [HANDLE_W-1:0] handle;
        logic [LENGTH_W-1:0] length;
        logic [POS_W-1:0]    pos;
        logic                typed;
        logic                typed_full;
    } stim_row_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    logic                  s_command;
    logic [HANDLE_W-1:0]   s_entry_handle;
    logic [LENGTH_W-1:0]   s_entry_length;
    logic [POS_W-1:0]      s_byte_position;
    logic                  m_valid;
    logic                  m_ready;
    logic                  m_found;
    logic [SLOT_OUT_W-1:0] m_slot_index;
    logic [HANDLE_W-1:0]   m_found_handle;
    logic [LENGTH_W-1:0]   m_found_length;
    logic [LENGTH_W-1:0]   m_byte_in_record;
    logic                  m_ring_full;

    // model state
    logic [HANDLE_W-1:0] ring_handle [RING_DEPTH];
    logic [LENGTH_W-1:0] ring_len    [RING_DEPTH];
    int                  wr_slot;
    int                  rd_slot;
    logic                ring_is_full;

    lookup_result_t pending_results [$];
    stim_row_t      directed_rows   [$];
    int             error_count;
    int             results_seen;
    int             cycle_count;
    bit             tx_idle_on;

    ring_of_writes_offset_lookup_core #(
        .RING_DEPTH (RING_DEPTH)
    ) dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_command        (s_command),
        .s_entry_handle   (s_entry_handle),
        .s_entry_length   (s_entry_length),
        .s_byte_position  (s_byte_position),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_found          (m_found),
        .m_slot_index     (m_slot_index),
        .m_found_handle   (m_found_handle),
        .m_found_length   (m_found_length),
        .m_byte_in_record (m_byte_in_record),
        .m_ring_full      (m_ring_full)
    );

    initial aclk = 1'b0;
    always #10 aclk = ~aclk;

    initial begin
        aresetn = 1'b0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
    end

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60) return 0;
        if (roll < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic int stored_count();
        if (ring_is_full) return RING_DEPTH;
        return (wr_slot + RING_DEPTH - rd_slot) % RING_DEPTH;
    endfunction

    function automatic lookup_result_t ring_step(input logic cmd,
                                                 input logic [HANDLE_W-1:0] handle,
                                                 input logic [LENGTH_W-1:0] length,
                                                 input logic [POS_W-1:0] pos);
        lookup_result_t r;
        int             count;
        int             k;
        int             s;
        int unsigned    base;
        r = '0;
        if (cmd == CMD_ADD) begin
            ring_handle[wr_slot] = handle;
            ring_len[wr_slot]    = length;
            if (ring_is_full) rd_slot = (rd_slot + 1) % RING_DEPTH;
            wr_slot      = (wr_slot + 1) % RING_DEPTH;
            ring_is_full = (wr_slot == rd_slot);
        end else begin
            count = stored_count();
            s     = rd_slot;
            base  = 0;
            for (k = 0; k < count; k++) begin
                if (!r.found && (pos < base + ring_len[s])) begin
                    r.found  = 1'b1;
                    r.slot   = s[SLOT_OUT_W-1:0];
                    r.handle = ring_handle[s];
                    r.length = ring_len[s];
                    r.offset = LENGTH_W'(pos - base);
                end
                base = base + ring_len[s];
                s    = (s + 1) % RING_DEPTH;
            end
        end
        r.full = ring_is_full;
        return r;
    endfunction

    task automatic add_row(input logic cmd, input logic [HANDLE_W-1:0] handle,
                           input logic [LENGTH_W-1:0] length, input logic [POS_W-1:0] pos,
                           input logic typed, input logic typed_full);
        stim_row_t row;
        row.cmd        = cmd;
        row.handle     = handle;
        row.length     = length;
        row.pos        = pos;
        row.typed      = typed;
        row.typed_full = typed_full;
        directed_rows.push_back(row);
    endtask

    task automatic send_item(input stim_row_t row);
        int             gap;
        lookup_result_t r;
        gap = tx_idle_on ? pick_gap() : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid         <= 1'b1;
        s_command       <= row.cmd;
        s_entry_handle  <= row.handle;
        s_entry_length  <= row.length;
        s_byte_position <= row.pos;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        r = ring_step(row.cmd, row.handle, row.length, row.pos);
        if (row.typed) begin
            r      = '0;
            r.full = row.typed_full;
        end
        pending_results.push_back(r);
    endtask

    task automatic report_field(input string name, input logic [HANDLE_W-1:0] exp_val,
                                input logic [HANDLE_W-1:0] act_val);
        if (exp_val !== act_val) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h",
                     $time, name, exp_val, act_val);
            error_count++;
        end
    endtask

    // stimulus
    initial begin
        stim_row_t   row;
        int          i;
        int          k;
        int          s;
        int          roll;
        int          add_pct;
        int unsigned total;

        s_valid         = 1'b0;
        s_command       = CMD_ADD;
        s_entry_handle  = '0;
        s_entry_length  = '0;
        s_byte_position = '0;
        tx_idle_on      = 1'b1;
        for (i = 0; i < RING_DEPTH; i++) begin
            ring_handle[i] = '0;
            ring_len[i]    = '0;
        end
        wr_slot      = 0;
        rd_slot      = 0;
        ring_is_full = 1'b0;

        add_row(CMD_FIND, 32'h0, 16'h0, 20'h0, 1'b1, 1'b0);
        add_row(CMD_ADD, 32'hFFFF_FFFF, 16'h0000, 20'hFFFFF, 1'b1, 1'b0);
        add_row(CMD_ADD, 32'h0000_0000, 16'hFFFF, 20'h00000, 1'b1, 1'b0);
        add_row(CMD_FIND, 32'hFFFF_FFFF, 16'hFFFF, 20'h00000, 1'b0, 1'b0);
        add_row(CMD_FIND, 32'h0, 16'h0, 20'h0FFFE, 1'b0, 1'b0);
        add_row(CMD_FIND, 32'h0, 16'h0, 20'h0FFFF, 1'b1, 1'b0);
        add_row(CMD_FIND, 32'h0, 16'h0, 20'hFFFFF, 1'b1, 1'b0);
        for (i = 0; i < 14; i++) begin
            add_row(CMD_ADD, 32'hA500_0000 + i, LENGTH_W'(i + 1), POS_W'($urandom),
                    1'b1, i == 13);
        end
        add_row(CMD_FIND, 32'h0, 16'h0, 20'h00000, 1'b0, 1'b0);
        add_row(CMD_ADD, 32'h5A5A_5A5A, 16'h0007, 20'h12345, 1'b1, 1'b1);
        add_row(CMD_FIND, 32'h0, 16'h0, 20'hFFFFF, 1'b1, 1'b1);
        add_row(CMD_FIND, 32'h0, 16'h0, 20'h10004, 1'b0, 1'b0);

        @(posedge aclk);
        while (!aresetn) @(posedge aclk);

        foreach (directed_rows[i]) send_item(directed_rows[i]);

        add_pct = 50;
        for (i = 0; i < RAND_ITEMS; i++) begin
            if (i % 100 == 0) begin
                tx_idle_on = ($urandom_range(0, 3) != 0);
                add_pct    = $urandom_range(0, 2) * 20 + 30;
            end
            row.handle = $urandom;
            row.pos    = POS_W'($urandom);
            roll       = $urandom_range(0, 99);
            if (roll < 15)      row.length = '0;
            else if (roll < 30) row.length = '1;
            else if (roll < 70) row.length = LENGTH_W'($urandom_range(1, 64));
            else                row.length = LENGTH_W'($urandom);
            row.typed      = 1'b0;
            row.typed_full = 1'b0;
            if ($urandom_range(0, 99) < add_pct) begin
                row.cmd = CMD_ADD;
            end else begin
                row.cmd = CMD_FIND;
                total   = 0;
                s       = rd_slot;
                for (k = 0; k < stored_count(); k++) begin
                    total = total + ring_len[s];
                    s     = (s + 1) % RING_DEPTH;
                end
                roll = $urandom_range(0, 99);
                if (total > 0) begin
                    if (roll < 55)      row.pos = POS_W'($urandom_range(0, total - 1));
                    else if (roll < 65) row.pos = POS_W'(total);
                    else if (roll < 75) row.pos = POS_W'(total - 1);
                end
            end
            send_item(row);
        end
        s_valid <= 1'b0;

        while (pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
        if (error_count == 0)
            $display("ring_of_writes_offset_lookup_core_tb: PASS");
        else
            $display("ring_of_writes_offset_lookup_core_tb: FAIL");
        $finish;
    end

    // result side: random stalls, one long hold-off, checking
    initial begin
        lookup_result_t exp_r;
        int             hold_left;
        int             rx_cycle;
        bit             rx_idle_on;
        bit             pressure_done;

        m_ready       = 1'b0;
        error_count   = 0;
        results_seen  = 0;
        hold_left     = 0;
        rx_cycle      = 0;
        rx_idle_on    = 1'b1;
        pressure_done = 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) begin
                if (pending_results.size() == 0) begin
                    $display("%0t: result beat with nothing expected", $time);
                    error_count++;
                end else begin
                    exp_r = pending_results.pop_front();
                    report_field("found", exp_r.found, m_found);
                    report_field("slot_index", exp_r.slot, m_slot_index);
                    report_field("found_handle", exp_r.handle, m_found_handle);
                    report_field("found_length", exp_r.length, m_found_length);
                    report_field("byte_in_record", exp_r.offset, m_byte_in_record);
                    report_field("ring_full", exp_r.full, m_ring_full);
                end
                results_seen++;
            end
            rx_cycle++;
            if (rx_cycle % 200 == 0) rx_idle_on = ($urandom_range(0, 3) != 0);
            if (!pressure_done && results_seen >= 300) begin
                hold_left     = 400;
                pressure_done = 1'b1;
            end
            if (!aresetn) begin
                m_ready <= 1'b0;
            end else if (hold_left > 0) begin
                m_ready <= 1'b0;
                hold_left--;
            end else begin
                m_ready <= 1'b1;
                if (rx_idle_on && $urandom_range(0, 3) == 0) hold_left = pick_gap();
            end
        end
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("ring_of_writes_offset_lookup_core_tb: FAIL");
        $finish;
    end

endmodule
